### hdl/surjection_count_mod_prime_unit_macros.svh
// Assertion macros for the surjection count unit
`ifndef SURJECTION_COUNT_MOD_PRIME_UNIT_MACROS_SVH
`define SURJECTION_COUNT_MOD_PRIME_UNIT_MACROS_SVH
// implication checked every edge outside reset
`define SCM_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// next-cycle implication
`define SCM_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

### hdl/scm_pkg.sv
//------------------------------------------------------------------------------
// scm_pkg
// Constants and types for the surjection count unit.
//------------------------------------------------------------------------------
package scm_pkg;
    localparam int MAX_N = 4096;
    localparam int NW = 13;
    localparam int AW = 13;
    localparam int VW = 30;
    localparam logic [VW-1:0] MOD = 30'd1000000007;
    localparam logic [VW-1:0] MOD_EXP = 30'd1000000005;
    // floor(2^60 / MOD), the Barrett reciprocal
    localparam logic [VW:0] BARRETT_M = 31'd1152921496;
    // twice the modulus, 32 bits wide for the final correction
    localparam logic [31:0] MOD_X2 = 32'd2000000014;

    typedef enum logic [4:0] {
        S_IDLE, S_FACT_RD, S_FACT_MUL, S_FACT_WAIT,
        S_PW_INIT, S_PW_STEP, S_PW_SQ, S_PW_WAIT, S_PW_SQW,
        S_INV_SET, S_INV_RD, S_INV_MUL, S_INV_WAIT,
        S_SUM_RD, S_SUM_M1, S_SUM_M1W, S_SUM_M2, S_SUM_M2W,
        S_SUM_M3, S_SUM_M3W, S_SUM_ACC, S_OUT
    } t_state;
endpackage

### hdl/scm_if.sv
//------------------------------------------------------------------------------
// scm_if
// Valid/ready channel carrying one payload word.
//------------------------------------------------------------------------------
interface scm_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hdl/scm_modmul.sv
//------------------------------------------------------------------------------
// scm_modmul
// Multi-cycle modular multiplier: 30x30 product, then Barrett reduction, all
// on one 32x32 multiplier. o_p holds the result while o_done is high.
//------------------------------------------------------------------------------
module scm_modmul (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [scm_pkg::VW-1:0] i_a,
    input  logic [scm_pkg::VW-1:0] i_b,
    output logic                   o_done,
    output logic [scm_pkg::VW-1:0] o_p
);
    import scm_pkg::*;
    logic [VW-1:0]   r_a, r_b;
    logic [2*VW-1:0] r_prod;
    logic [2*VW+1:0] r_qe;
    logic [31:0]     r_qp;
    logic [VW-1:0]   r_p;
    logic            r_s1, r_s2, r_s3, r_s4, r_done;
    logic [31:0]     mul_x, mul_y;
    logic [63:0]     mul_z;
    logic [31:0]     rem, n_p;

    // shared multiplier: product, then quotient estimate, then quotient times MOD
    always_comb begin
        mul_x = {2'b00, r_a};
        mul_y = {2'b00, r_b};
        if (r_s2) begin
            mul_x = {1'b0, r_prod[2*VW-1:VW-1]};
            mul_y = {1'b0, BARRETT_M};
        end else if (r_s3) begin
            mul_x = {1'b0, r_qe[2*VW+1:VW+1]};
            mul_y = {2'b00, MOD};
        end
    end
    assign mul_z = mul_x * mul_y;

    // remainder is below 3*MOD, one subtraction of 2*MOD or of MOD corrects it
    always_comb begin
        rem = r_prod[31:0] - r_qp;
        if (rem >= MOD_X2)
            n_p = rem - MOD_X2;
        else if (rem >= {2'b00, MOD})
            n_p = rem - {2'b00, MOD};
        else
            n_p = rem;
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
        end
        if (r_s1) r_prod <= mul_z[2*VW-1:0];
        if (r_s2) r_qe <= mul_z[2*VW+1:0];
        if (r_s3) r_qp <= mul_z[31:0];
        if (r_s4) r_p <= n_p[VW-1:0];
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= 1'b0; r_s2 <= 1'b0; r_s3 <= 1'b0; r_s4 <= 1'b0; r_done <= 1'b0;
        end else begin
            r_s1 <= i_start; r_s2 <= r_s1; r_s3 <= r_s2; r_s4 <= r_s3; r_done <= r_s4;
        end
    end

    assign o_done = r_done;
    assign o_p = r_p;
endmodule

### hdl/surjection_count_mod_prime_unit.sv
//------------------------------------------------------------------------------
// surjection_count_mod_prime_unit
// Surjection count n->k modulo 1e9+7 by inclusion-exclusion.
//------------------------------------------------------------------------------
// Work: a word needs 2n + 45 + (k+1)*(3 + b + w) modular products on the shared
// multiplier, b and w the bit length and ones count of n. When k > n only the
// 2n + 45 table products are made, and a rejected n makes none. The result word
// then waits for out_ready.
// Throughput: one word at a time; in_ready stays low until the result word leaves.
// Reset: synchronous active low; tables are not cleared, every word with n up to MAX_N rebuilds them.
module surjection_count_mod_prime_unit (
    input  logic i_clk,
    input  logic i_rst_n,
    scm_if.sink   i_in,
    scm_if.source o_out
);
    import scm_pkg::*;
    `include "surjection_count_mod_prime_unit_macros.svh"

    t_state r_st, n_st;
    logic [VW-1:0] fact_mem [0:MAX_N];
    logic [VW-1:0] ifact_mem [0:MAX_N];
    logic [NW-1:0] r_n, r_k, r_i, r_j;
    logic [VW-1:0] r_rd_f, r_rd_i, r_rd_i2;
    logic [VW-1:0] r_pb, r_pr, r_pe, r_t, r_acc, r_res;
    logic          r_bad;
    logic          mstart, mdone;
    logic [VW-1:0] ma, mb, mp;
    logic          f_we, i_we;
    logic [AW-1:0] f_wa, i_wa, f_ra, i_ra, i_ra2;
    logic [VW-1:0] f_wd, i_wd;
    logic [VW:0]   addv;

    scm_modmul u_mul (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mstart),
        .i_a(ma), .i_b(mb), .o_done(mdone), .o_p(mp));

    // table memories
    always_ff @(posedge i_clk) begin
        if (f_we) fact_mem[f_wa] <= f_wd;
        if (i_we) ifact_mem[i_wa] <= i_wd;
        r_rd_f <= fact_mem[f_ra];
        r_rd_i <= ifact_mem[i_ra];
        r_rd_i2 <= ifact_mem[i_ra2];
    end

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE:      if (i_in.valid) n_st = S_FACT_RD;
            S_FACT_RD:   n_st = (r_bad) ? S_OUT : ((r_i > r_n) ? S_PW_INIT : S_FACT_MUL);
            S_FACT_MUL:  n_st = S_FACT_WAIT;
            S_FACT_WAIT: if (mdone) n_st = S_FACT_RD;
            S_PW_INIT:   n_st = S_PW_STEP;
            S_PW_STEP:   n_st = (r_pe == '0) ? (r_j == '0 ? S_INV_SET : S_SUM_M3)
                                : (r_pe[0] ? S_PW_WAIT : S_PW_SQ);
            S_PW_WAIT:   if (mdone) n_st = S_PW_SQ;
            S_PW_SQ:     n_st = S_PW_SQW;
            S_PW_SQW:    if (mdone) n_st = S_PW_STEP;
            S_INV_SET:   n_st = (r_n == '0) ? S_SUM_RD : S_INV_RD;
            S_INV_RD:    n_st = S_INV_MUL;
            S_INV_MUL:   n_st = S_INV_WAIT;
            S_INV_WAIT:  if (mdone) n_st = (r_i == 13'd1) ? S_SUM_RD : S_INV_RD;
            S_SUM_RD:    n_st = (r_k > r_n || r_i > r_k) ? S_OUT : S_SUM_M1;
            S_SUM_M1:    n_st = S_SUM_M1W;
            S_SUM_M1W:   if (mdone) n_st = S_SUM_M2;
            S_SUM_M2:    n_st = S_SUM_M2W;
            S_SUM_M2W:   if (mdone) n_st = S_PW_STEP;
            S_SUM_M3:    n_st = S_SUM_M3W;
            S_SUM_M3W:   if (mdone) n_st = S_SUM_ACC;
            S_SUM_ACC:   n_st = S_SUM_RD;
            S_OUT:       if (o_out.ready) n_st = S_IDLE;
            default:     n_st = S_IDLE;
        endcase
    end

    // outputs and datapath control
    always_comb begin
        mstart = 1'b0; ma = r_t; mb = r_t;
        f_we = 1'b0; f_wa = r_i; f_wd = mp;
        i_we = 1'b0; i_wa = r_i - 13'd1; i_wd = mp;
        f_ra = r_i - 13'd1; i_ra = r_i; i_ra2 = r_k - r_i;
        addv = '0;
        case (r_st)
            // factorial 0 goes in as a word with n up to MAX_N is taken
            S_IDLE: begin
                f_we = i_in.valid && (i_in.data[2*NW-1:NW] <= NW'(MAX_N));
                f_wa = '0; f_wd = 30'd1;
            end
            S_FACT_MUL: begin
                mstart = 1'b1; ma = r_rd_f; mb = {17'd0, r_i};
            end
            S_FACT_WAIT: f_we = mdone;
            S_PW_INIT:  f_ra = r_n;
            S_PW_WAIT:  ;
            S_PW_STEP:  begin
                mstart = (r_pe != '0) && r_pe[0]; ma = r_pr; mb = r_pb;
            end
            S_PW_SQ:    begin mstart = 1'b1; ma = r_pb; mb = r_pb; end
            S_INV_SET:  begin i_we = 1'b1; i_wa = r_n; i_wd = r_pr; end
            S_INV_RD:   i_ra = r_i;
            S_INV_MUL:  begin mstart = 1'b1; ma = r_rd_i; mb = {17'd0, r_i}; end
            S_INV_WAIT: i_we = mdone;
            S_SUM_RD:   begin f_ra = r_k; i_ra = r_i; i_ra2 = r_k - r_i; end
            S_SUM_M1:   begin mstart = 1'b1; ma = r_rd_f; mb = r_rd_i; end
            S_SUM_M2:   begin mstart = 1'b1; ma = mp; mb = r_rd_i2; end
            S_SUM_M3:   begin mstart = 1'b1; ma = r_t; mb = r_pr; end
            S_SUM_ACC:  addv = r_i[0] ? ({1'b0, r_acc} + {1'b0, MOD - mp})
                                      : ({1'b0, r_acc} + {1'b0, mp});
            default:    ;
        endcase
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_res <= '0;
        end else begin
            r_st <= n_st;
            case (r_st)
                S_IDLE: if (i_in.valid) begin
                    r_n <= i_in.data[2*NW-1:NW]; r_k <= i_in.data[NW-1:0];
                    r_bad <= i_in.data[2*NW-1:NW] > NW'(MAX_N);
                    r_i <= 13'd1; r_acc <= '0; r_j <= '0;
                end
                S_FACT_WAIT: if (mdone) r_i <= r_i + 13'd1;
                S_PW_INIT: begin
                    r_pb <= (r_n == '0) ? 30'd1 : r_rd_f; r_pr <= 30'd1; r_pe <= MOD_EXP;
                end
                S_PW_STEP: if (r_pe == '0 && r_j == '0) r_i <= r_n;
                S_PW_WAIT: if (mdone) r_pr <= mp;
                S_PW_SQW:  if (mdone) begin r_pb <= mp; r_pe <= r_pe >> 1; end
                S_INV_SET: if (r_n == '0) r_i <= '0;
                S_INV_WAIT: if (mdone) begin
                    r_i <= (r_i == 13'd1) ? 13'd0 : r_i - 13'd1;
                end
                S_SUM_M2W: if (mdone) begin
                    r_t <= mp; r_pb <= {17'd0, r_k - r_i}; r_pr <= 30'd1;
                    r_pe <= {17'd0, r_n}; r_j <= 13'd1;
                end
                S_SUM_ACC: begin
                    r_acc <= (addv >= {1'b0, MOD}) ? VW'(addv - {1'b0, MOD}) : addv[VW-1:0];
                    r_i <= r_i + 13'd1;
                end
                S_SUM_RD: if (r_k > r_n || r_i > r_k) r_res <= r_bad ? '0 : r_acc;
                S_FACT_RD: if (r_bad) r_res <= '0;
                default: ;
            endcase
        end
    end

    assign i_in.ready = (r_st == S_IDLE);
    assign o_out.valid = (r_st == S_OUT);
    assign o_out.data = r_res;

    `SCM_ASSERT_IMP(a_busy_ready, i_clk, i_rst_n, r_st != S_IDLE, !i_in.ready)
    `SCM_ASSERT_IMP(a_res_range, i_clk, i_rst_n, o_out.valid, o_out.data < MOD)
    `SCM_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out.valid && !o_out.ready, o_out.valid)
endmodule

### test/surjection_check.sv
//------------------------------------------------------------------------------
// surjection_check
// Watches both channels of the surjection count unit. Every accepted input word
// gets its count predicted here. Each accepted output word is compared with the
// oldest prediction still waiting. Mismatches are counted.
//------------------------------------------------------------------------------
module surjection_check (
    input  logic i_clk,
    input  logic i_rst_n,
    scm_if       in_mon,
    scm_if       out_mon,
    output int   o_fail_count,
    output int   o_waiting
);
    import scm_pkg::*;

    localparam longint unsigned PRIME = 64'd1000000007;

    logic [VW-1:0] pending_counts[$];
    longint unsigned fact_tab[0:MAX_N];
    longint unsigned inv_fact_tab[0:MAX_N];

    function automatic longint unsigned mul_p(longint unsigned a, longint unsigned b);
        return (a * b) % PRIME;
    endfunction

    function automatic longint unsigned pow_p(longint unsigned b, longint unsigned e);
        longint unsigned r;
        r = 1;
        b = b % PRIME;
        while (e != 0) begin
            if (e[0]) r = mul_p(r, b);
            b = mul_p(b, b);
            e = e >> 1;
        end
        return r;
    endfunction

    // inclusion-exclusion over the number of boxes left empty
    function automatic logic [VW-1:0] onto_count(int unsigned n, int unsigned k);
        longint unsigned acc;
        longint unsigned term;
        if (n > MAX_N) return '0;
        fact_tab[0] = 1;
        for (int unsigned i = 1; i <= n; i++) fact_tab[i] = mul_p(fact_tab[i-1], i);
        inv_fact_tab[n] = pow_p(fact_tab[n], PRIME - 2);
        for (int unsigned i = n; i >= 1; i--) inv_fact_tab[i-1] = mul_p(inv_fact_tab[i], i);
        acc = 0;
        if (k <= n) begin
            for (int unsigned i = 0; i <= k; i++) begin
                term = mul_p(mul_p(fact_tab[k], inv_fact_tab[i]), inv_fact_tab[k-i]);
                term = mul_p(term, pow_p(k - i, n));
                if (i % 2 == 1) acc = (acc + PRIME - term) % PRIME;
                else acc = (acc + term) % PRIME;
            end
        end
        return acc[VW-1:0];
    endfunction

    assign o_waiting = pending_counts.size();

    // predict on input words, compare on output words
    always @(posedge i_clk) begin
        logic [VW-1:0] want;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (in_mon.valid && in_mon.ready)
                pending_counts.push_back(onto_count(in_mon.data[NW+AW-1:AW],
                                                    in_mon.data[AW-1:0]));
            if (out_mon.valid && out_mon.ready) begin
                if (pending_counts.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected output word: count_mod=%0d", out_mon.data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = pending_counts.pop_front();
                    if (want !== out_mon.data) begin
                        if (o_fail_count < 10)
                            $display("count_mod mismatch: expected %0d actual %0d",
                                     want, out_mon.data);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

### test/tb.sv
//------------------------------------------------------------------------------
// tb
// Stimulus for the surjection count unit: directed corner words, then random
// small (n, k) pairs mixed with rejected oversize counts, random gaps on both
// sides. The checker beside the block does the prediction and comparison.
//------------------------------------------------------------------------------
module tb;
    import scm_pkg::*;

    localparam int IDLE_LIMIT = 500000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   waiting;
    int   idle_cycles;

    scm_if #(.W(NW+AW)) in_ch ();
    scm_if #(.W(VW))    out_ch ();

    surjection_count_mod_prime_unit dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    surjection_check checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .in_mon      (in_ch),
        .out_mon     (out_ch),
        .o_fail_count(fail_count),
        .o_waiting   (waiting)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 40) return 0;
        if (r < 80) return $urandom_range(1, 2);
        if (r < 95) return $urandom_range(3, 10);
        return $urandom_range(20, 60);
    endfunction

    // result side stalls
    always begin
        int g;
        @(negedge i_clk);
        out_ch.ready <= 1'b1;
        g = pick_gap();
        if (g > 0) begin
            @(negedge i_clk);
            out_ch.ready <= 1'b0;
            repeat (g - 1) @(negedge i_clk);
        end
    end

    // watchdog on cycles without any accepted word
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_word(int unsigned n, int unsigned k);
        int g;
        @(negedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.data  <= {n[NW-1:0], k[AW-1:0]};
        do @(posedge i_clk); while (!in_ch.ready);
        g = pick_gap();
        if (g > 0) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            repeat (g - 1) @(negedge i_clk);
        end
    endtask

    // stop sending and wait for every predicted word to come back
    task automatic drain();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        wait (waiting == 0);
    endtask

    initial begin
        int unsigned n;
        int unsigned k;
        idle_cycles  = 0;
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // corners: empty map, zero boxes, zero items, k > n, rejected n, MAX_N
        send_word(0, 0);
        send_word(0, 1);
        send_word(1, 0);
        send_word(1, 1);
        send_word(2, 3);
        send_word(3, 2);
        send_word(5, 5);
        send_word(6, 3);
        send_word(12, 7);
        send_word(20, 20);
        send_word(10, 4096);
        send_word(1, 8191);
        send_word(MAX_N + 1, 1);
        send_word(8191, 8191);
        send_word(8191, 0);
        send_word(MAX_N, 8191);
        send_word(7, 4);

        // hold off until everything has drained
        drain();

        for (int i = 0; i < 84; i++) begin
            if (i == 42) drain();
            if ($urandom_range(9) == 0) begin
                n = $urandom_range(8191, MAX_N + 1);
                k = $urandom_range(8191);
            end else begin
                n = $urandom_range(10);
                k = $urandom_range(n + 1);
            end
            send_word(n, k);
        end

        drain();
        repeat (200) @(posedge i_clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

### files.f
+incdir+hdl
hdl/scm_pkg.sv
hdl/scm_if.sv
hdl/scm_modmul.sv
hdl/surjection_count_mod_prime_unit.sv
test/surjection_check.sv
test/tb.sv
